@@ rtl/packed_lifetime_pool_macros.svh @@
// Assertion helpers for the checker file of the lifetime pool.
`ifndef PACKED_LIFETIME_POOL_MACROS_SVH
`define PACKED_LIFETIME_POOL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/plp_pkg.sv @@
package plp_pkg;

   // Operation codes carried in the func field.
   typedef logic [2:0] func_type;
   localparam func_type FN_WRITE = 3'd0;
   localparam func_type FN_READ  = 3'd1;
   localparam func_type FN_WAKE  = 3'd2;
   localparam func_type FN_KILL  = 3'd3;
   localparam func_type FN_TICK  = 3'd4;

   // Result status codes.
   typedef logic [1:0] status_type;
   localparam status_type ST_DONE    = 2'd0;
   localparam status_type ST_RANGE   = 2'd1;
   localparam status_type ST_IGNORED = 2'd2;

   // Counts and the slot limit share one 11-bit width.
   typedef logic [10:0] count_type;
   localparam count_type LIMIT_RESET = 11'd1024;

endpackage

@@ rtl/plp_ram.sv @@
module plp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/packed_lifetime_pool.sv @@
// Packed lifetime pool. Slots hold a payload word and a signed 32-bit lifetime in one
// single-port-read RAM; the alive entries are kept packed below the alive count. Every
// item gets exactly one result, and req_ready is high only while the sequencer is idle.
// Steps per item, from acceptance to the result register: write, out-of-range and ignored
// operations go straight to the result; read reads its slot; wake and kill read both
// slots, then write both slots. A tick reads and updates every alive entry and swaps each
// entry that expires with the last alive entry, through the one read port and one write
// port of the slot RAM. pool_limit must be written through csr_we/csr_wdata only while
// no item is in flight; the block itself does not enforce this.
module packed_lifetime_pool
   import plp_pkg::*;
#(
   parameter int POOL_DEPTH   = 1024,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [10:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic [9:0]         req_entry_index,
   input  logic [63:0]        req_entry_data,
   input  logic [30:0]        req_entry_lifetime,
   input  logic [15:0]        req_tick_delta,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [10:0]        rsp_alive_now,
   output logic [63:0]        rsp_read_data,
   output logic signed [31:0] rsp_read_lifetime,
   output logic [1:0]         rsp_status,
   output logic [10:0]        rsp_expired_count
);

   localparam int AW = $clog2(POOL_DEPTH);
   localparam int W  = PAYLOAD_BITS + 32;
   localparam int CAP_INT = (POOL_DEPTH > 2047) ? 2047 : POOL_DEPTH;
   localparam count_type DEPTH_CAP = count_type'(CAP_INT);

   typedef enum logic [3:0] {
      S_IDLE, S_RD_ADR, S_RD_CAP, S_RD_A, S_RD_B, S_WR_A, S_WR_B,
      S_TK_RD, S_TK_EVAL, S_TK_ACT, S_RESP
   } state_type;

   state_type      state_ff, state_in;
   count_type      limit_ff, limit_in;
   count_type      alive_ff, alive_in;
   count_type      i_ff, i_in;
   count_type      expired_ff, expired_in;
   logic [AW-1:0]  a_ff, a_in;
   logic [AW-1:0]  b_ff, b_in;
   logic [W-1:0]   hold_ff, hold_in;
   logic [W-1:0]   rd_word_ff, rd_word_in;
   logic [15:0]    delta_ff, delta_in;
   logic           kill_ff, kill_in;
   logic           tick_ff, tick_in;
   status_type     status_ff, status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   count_type      rsp_alive_ff, rsp_alive_in;
   logic [63:0]    rsp_data_ff, rsp_data_in;
   logic [31:0]    rsp_life_ff, rsp_life_in;
   status_type     rsp_status_ff, rsp_status_in;
   count_type      rsp_expired_ff, rsp_expired_in;

   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [W-1:0]   ram_wdata;
   logic [AW-1:0]  ram_raddr;
   logic [W-1:0]   ram_rdata;

   count_type      limit_eff;
   count_type      index_wide;
   logic           accept;
   logic [32:0]    life_diff;
   logic [31:0]    life_new;
   logic           life_dead;

   plp_ram #(
      .WIDTH (W),
      .DEPTH (POOL_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The limit in force never exceeds the number of physical slots.
   assign limit_eff  = (limit_ff < DEPTH_CAP) ? limit_ff : DEPTH_CAP;
   assign index_wide = {1'b0, req_entry_index};
   assign accept     = req_valid && req_ready;

   // Lifetime update: subtract the delta, saturate at the most negative value.
   assign life_diff = {ram_rdata[W-1], ram_rdata[W-1:PAYLOAD_BITS]} - {17'd0, delta_ff};
   assign life_new  = (life_diff[32] && !life_diff[31]) ? 32'h8000_0000 : life_diff[31:0];
   assign life_dead = life_new[31] || (life_new == 32'd0);

   // Read address follows the step of the sequencer.
   always_comb begin
      unique case (state_ff)
         S_RD_B, S_TK_ACT: ram_raddr = b_ff;
         S_TK_RD:          ram_raddr = AW'(i_ff);
         default:          ram_raddr = a_ff;
      endcase
   end

   // Sequencer and result register next-state logic.
   always_comb begin
      state_in       = state_ff;
      limit_in       = csr_we ? csr_wdata : limit_ff;
      alive_in       = alive_ff;
      i_in           = i_ff;
      expired_in     = expired_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      hold_in        = hold_ff;
      rd_word_in     = rd_word_ff;
      delta_in       = delta_ff;
      kill_in        = kill_ff;
      tick_in        = tick_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_alive_in   = rsp_alive_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_life_in    = rsp_life_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_expired_in = rsp_expired_ff;
      ram_we         = 1'b0;
      ram_waddr      = a_ff;
      ram_wdata      = hold_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in  = ST_DONE;
               expired_in = '0;
               rd_word_in = '0;
               tick_in    = 1'b0;
               state_in   = S_RESP;
               if (req_func <= FN_KILL && index_wide >= limit_eff) begin
                  status_in = ST_RANGE;
               end else begin
                  case (req_func)
                     FN_WRITE: begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(req_entry_index);
                        ram_wdata = {1'b0, req_entry_lifetime,
                                     req_entry_data[PAYLOAD_BITS-1:0]};
                     end
                     FN_READ: begin
                        a_in     = AW'(req_entry_index);
                        state_in = S_RD_ADR;
                     end
                     FN_WAKE: begin
                        if (alive_ff >= limit_eff) begin
                           status_in = ST_IGNORED;
                        end else begin
                           a_in     = AW'(req_entry_index);
                           b_in     = AW'(alive_ff);
                           alive_in = alive_ff + 11'd1;
                           state_in = S_RD_A;
                        end
                     end
                     FN_KILL: begin
                        if (alive_ff == '0) begin
                           status_in = ST_IGNORED;
                        end else begin
                           a_in     = AW'(req_entry_index);
                           b_in     = AW'(alive_ff - 11'd1);
                           alive_in = alive_ff - 11'd1;
                           state_in = S_RD_A;
                        end
                     end
                     FN_TICK: begin
                        i_in     = '0;
                        delta_in = req_tick_delta;
                        tick_in  = 1'b1;
                        state_in = S_TK_RD;
                     end
                     default: begin
                        state_in = S_RESP;
                     end
                  endcase
               end
            end
         end
         // Read: S_RD_ADR presents the address, S_RD_CAP captures the registered word.
         S_RD_ADR: state_in = S_RD_CAP;
         S_RD_CAP: begin
            rd_word_in = ram_rdata;
            state_in   = S_RESP;
         end
         // Swap: fetch slot a, then slot b, write b's word to a and a's word to b.
         S_RD_A: state_in = S_RD_B;
         S_RD_B: begin
            hold_in  = ram_rdata;
            state_in = S_WR_A;
         end
         S_WR_A: begin
            ram_we    = 1'b1;
            ram_waddr = a_ff;
            ram_wdata = ram_rdata;
            state_in  = S_WR_B;
         end
         S_WR_B: begin
            ram_we    = 1'b1;
            ram_waddr = b_ff;
            ram_wdata = hold_ff;
            state_in  = tick_ff ? S_TK_RD : S_RESP;
         end
         // Tick walk: one alive entry per pass, the index stays after a kill.
         S_TK_RD: begin
            state_in = (i_ff >= alive_ff) ? S_RESP : S_TK_EVAL;
         end
         S_TK_EVAL: begin
            hold_in  = {life_new, ram_rdata[PAYLOAD_BITS-1:0]};
            kill_in  = life_dead;
            a_in     = AW'(i_ff);
            b_in     = AW'(alive_ff - 11'd1);
            state_in = S_TK_ACT;
         end
         S_TK_ACT: begin
            if (kill_ff) begin
               alive_in   = alive_ff - 11'd1;
               expired_in = expired_ff + 11'd1;
               state_in   = S_WR_A;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = a_ff;
               ram_wdata = hold_ff;
               i_in      = i_ff + 11'd1;
               state_in  = S_TK_RD;
            end
         end
         // Hand the result over once the output register is free.
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_alive_in   = alive_ff;
               rsp_data_in    = 64'(rd_word_ff[PAYLOAD_BITS-1:0]);
               rsp_life_in    = rd_word_ff[W-1:PAYLOAD_BITS];
               rsp_status_in  = status_ff;
               rsp_expired_in = expired_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= LIMIT_RESET;
         alive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         alive_ff     <= alive_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
      end
      i_ff           <= i_in;
      expired_ff     <= expired_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      hold_ff        <= hold_in;
      rd_word_ff     <= rd_word_in;
      delta_ff       <= delta_in;
      kill_ff        <= kill_in;
      status_ff      <= status_in;
      rsp_alive_ff   <= rsp_alive_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_life_ff    <= rsp_life_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_expired_ff <= rsp_expired_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alive_now     = rsp_alive_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_read_lifetime = rsp_life_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_expired_count = rsp_expired_ff;

endmodule

@@ rtl/plp_checker.sv @@
`include "packed_lifetime_pool_macros.svh"

module plp_checker
   import plp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [10:0]        rsp_alive_now,
   input logic [63:0]        rsp_read_data,
   input logic signed [31:0] rsp_read_lifetime,
   input logic [1:0]         rsp_status,
   input logic [10:0]        rsp_expired_count
);

   // A stalled result stays valid and keeps its alive count, status and expired count.
   `PLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_alive_now) && $stable(rsp_status) && $stable(rsp_expired_count), "result changed while stalled")

   // The block works on one item at a time.
   `PLP_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second item taken while busy")

   // A rejected or ignored operation returns no data.
   `PLP_ASSERT_NOW(a_reject_clean, clock, reset, rsp_valid && rsp_status != ST_DONE, rsp_read_data == 64'd0 && rsp_read_lifetime == 32'sd0 && rsp_expired_count == 11'd0, "data on a rejected item")

   // Only the three defined status codes appear.
   `PLP_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status == ST_DONE || rsp_status == ST_RANGE || rsp_status == ST_IGNORED, "undefined status code")

endmodule

bind packed_lifetime_pool plp_checker u_plp_checker (.*);

@@ test/pool_model_pkg.sv @@
package pool_model_pkg;
   import plp_pkg::*;

   localparam int SLOT_COUNT = 1024;

   // One request item as it is offered on the req_ channel.
   typedef struct packed {
      func_type    func;
      logic [9:0]  index;
      logic [63:0] data;
      logic [30:0] lifetime;
      logic [15:0] delta;
   } pool_item_t;

   // One response item as it appears on the rsp_ channel.
   typedef struct packed {
      count_type          alive_now;
      logic [63:0]        read_data;
      logic signed [31:0] read_lifetime;
      status_type         status;
      count_type          expired;
   } pool_result_t;

   // Shadow copy of the pool that predicts each response and checks it against the block.
   class lifetime_pool_model;
      logic [63:0]  payload [SLOT_COUNT];
      int           lifetime [SLOT_COUNT];
      bit           written [SLOT_COUNT];
      int           alive;
      int           limit;
      pool_result_t pending_results [$];
      int           mismatches;
      int           checked;
      int           ticks;
      int           expired_total;

      function new();
         foreach (written[i]) begin
            written[i] = 1'b0;
            payload[i] = '0;
            lifetime[i] = 0;
         end
         alive = 0;
         limit = LIMIT_RESET;
         mismatches = 0;
         checked = 0;
         ticks = 0;
         expired_total = 0;
      endfunction

      // The limit in force never exceeds the number of physical slots.
      function int active_limit();
         return (limit < SLOT_COUNT) ? limit : SLOT_COUNT;
      endfunction

      function void set_limit(count_type value);
         limit = value;
      endfunction

      // Slots always move whole: payload, lifetime and whether they hold data.
      function void swap_slots(int a, int b);
         logic [63:0] word;
         int          level;
         bit          seen;
         word = payload[a];
         payload[a] = payload[b];
         payload[b] = word;
         level = lifetime[a];
         lifetime[a] = lifetime[b];
         lifetime[b] = level;
         seen = written[a];
         written[a] = written[b];
         written[b] = seen;
      endfunction

      // Update the shadow pool for an accepted item and queue the response it must give.
      function void apply_item(pool_item_t it);
         pool_result_t r;
         int           lim;
         int           slot;
         longint       level;
         r = '0;
         lim = active_limit();
         slot = int'(it.index);
         if (it.func <= FN_KILL && slot >= lim) begin
            r.status = ST_RANGE;
         end else begin
            case (it.func)
               FN_WRITE: begin
                  payload[slot] = it.data;
                  lifetime[slot] = int'({1'b0, it.lifetime});
                  written[slot] = 1'b1;
               end
               FN_READ: begin
                  r.read_data = payload[slot];
                  r.read_lifetime = lifetime[slot];
               end
               FN_WAKE: begin
                  if (alive >= lim) begin
                     r.status = ST_IGNORED;
                  end else begin
                     swap_slots(slot, alive);
                     alive++;
                  end
               end
               FN_KILL: begin
                  if (alive == 0) begin
                     r.status = ST_IGNORED;
                  end else begin
                     alive--;
                     swap_slots(slot, alive);
                  end
               end
               FN_TICK: begin
                  // An expired entry is replaced by the last alive one, so the same
                  // position is looked at again.
                  ticks++;
                  slot = 0;
                  while (slot < alive) begin
                     level = longint'(lifetime[slot]) - longint'(it.delta);
                     if (level < -64'sd2147483648)
                        level = -64'sd2147483648;
                     lifetime[slot] = int'(level);
                     if (level <= 0) begin
                        alive--;
                        swap_slots(slot, alive);
                        r.expired++;
                        expired_total++;
                     end else begin
                        slot++;
                     end
                  end
               end
               default: ;
            endcase
         end
         r.alive_now = count_type'(alive);
         pending_results.push_back(r);
      endfunction

      // Compare a response with the oldest outstanding prediction.
      function void check_result(pool_result_t got);
         pool_result_t want;
         if (pending_results.size() == 0) begin
            $error("response arrived with no item outstanding");
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.alive_now !== want.alive_now) begin
            $error("alive_now: expected %0d, got %0d", want.alive_now, got.alive_now);
            mismatches++;
         end
         if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            mismatches++;
         end
         if (got.read_lifetime !== want.read_lifetime) begin
            $error("read_lifetime: expected %0d, got %0d", want.read_lifetime,
                   got.read_lifetime);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.expired !== want.expired) begin
            $error("expired_count: expected %0d, got %0d", want.expired, got.expired);
            mismatches++;
         end
      endfunction
   endclass

endpackage

@@ test/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import plp_pkg::*;
   import pool_model_pkg::*;

   // Cycles without any handshake before the run is declared hung. The slowest
   // item is a tick over a full pool.
   localparam int STALL_LIMIT  = 20000;
   localparam int PHASE_COUNT  = 9;
   localparam int CALM_PHASE   = 4;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 400;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [10:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_func = '0;
   logic [9:0]         req_entry_index = '0;
   logic [63:0]        req_entry_data = '0;
   logic [30:0]        req_entry_lifetime = '0;
   logic [15:0]        req_tick_delta = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [10:0]        rsp_alive_now;
   logic [63:0]        rsp_read_data;
   logic signed [31:0] rsp_read_lifetime;
   logic [1:0]         rsp_status;
   logic [10:0]        rsp_expired_count;

   lifetime_pool_model pool_model;
   bit                 calm = 1'b0;
   int                 items_sent = 0;
   int                 results_seen = 0;
   int                 hold_left = 0;
   bit                 hold_done = 1'b0;
   int                 idle_cycles = 0;
   int                 limits_used = 0;

   int phase_limit [PHASE_COUNT] = '{2047, 16, 0, 1, 1024, 3, 64, 2, 1024};
   int phase_items [PHASE_COUNT] = '{200, 250, 60, 80, 250, 100, 200, 80, 180};

   packed_lifetime_pool #(
      .POOL_DEPTH   (1024),
      .PAYLOAD_BITS (64)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_entry_index    (req_entry_index),
      .req_entry_data     (req_entry_data),
      .req_entry_lifetime (req_entry_lifetime),
      .req_tick_delta     (req_tick_delta),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_alive_now      (rsp_alive_now),
      .rsp_read_data      (rsp_read_data),
      .rsp_read_lifetime  (rsp_read_lifetime),
      .rsp_status         (rsp_status),
      .rsp_expired_count  (rsp_expired_count)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: check every accepted item, then pick the next ready value.
   // Once, the receiver holds off long enough for the block to back up.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         pool_model.check_result('{rsp_alive_now, rsp_read_data, rsp_read_lifetime,
                                   rsp_status, rsp_expired_count});
         results_seen++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen == HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 30);
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic pool_item_t make_item(func_type func, int index, logic [63:0] data,
                                            logic [30:0] life, logic [15:0] delta);
      pool_item_t it;
      it.func = func;
      it.index = index[9:0];
      it.data = data;
      it.lifetime = life;
      it.delta = delta;
      return it;
   endfunction

   // Mostly short lifetimes so that ticks retire entries, with a few very long ones.
   function automatic logic [30:0] random_lifetime();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45)
         return 31'($urandom_range(0, 2000));
      else if (pick < 93)
         return 31'($urandom_range(0, 400000));
      else
         return 31'($urandom());
   endfunction

   function automatic logic [15:0] random_delta();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35)
         return 16'($urandom_range(0, 300));
      else if (pick < 40)
         return '0;
      else if (pick < 45)
         return '1;
      else
         return 16'($urandom());
   endfunction

   function automatic logic [63:0] random_payload();
      case ($urandom_range(9))
         0: return '1;
         1: return '0;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Random item that never makes the block read a slot that has not been written:
   // such an operation turns into a write of the slot in question.
   function automatic pool_item_t random_item();
      pool_item_t it;
      int         lim;
      int         pick;
      int         slot;
      lim = pool_model.active_limit();
      pick = $urandom_range(99);
      if (pick < 28)
         it.func = FN_WRITE;
      else if (pick < 43)
         it.func = FN_READ;
      else if (pick < 65)
         it.func = FN_WAKE;
      else if (pick < 75)
         it.func = FN_KILL;
      else if (pick < 96)
         it.func = FN_TICK;
      else
         it.func = func_type'(FN_TICK + $urandom_range(1, 3));
      if (lim == 0 || $urandom_range(99) < 15)
         slot = $urandom_range(1023);
      else
         slot = $urandom_range(lim - 1);
      it.data = random_payload();
      it.lifetime = random_lifetime();
      it.delta = random_delta();

      // Keep the alive population modest so that ticks stay short.
      if (it.func == FN_WAKE && pool_model.alive >= 40) begin
         it.func = FN_KILL;
         slot = $urandom_range(pool_model.alive - 1);
      end

      if (slot < lim) begin
         if (it.func == FN_READ && !pool_model.written[slot]) begin
            it.func = FN_WRITE;
         end else if (it.func == FN_KILL && pool_model.alive > 0
                      && !pool_model.written[slot]) begin
            it.func = FN_WRITE;
         end else if (it.func == FN_WAKE && pool_model.alive < lim) begin
            if (!pool_model.written[slot]) begin
               it.func = FN_WRITE;
            end else if (!pool_model.written[pool_model.alive]) begin
               it.func = FN_WRITE;
               slot = pool_model.alive;
            end
         end
      end
      it.index = slot[9:0];
      return it;
   endfunction

   // Offer one item and wait until it is accepted. Valid is lowered only for a gap,
   // so back-to-back items keep it high.
   task automatic send_item(input pool_item_t it);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < 30)
         gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_func <= it.func;
      req_entry_index <= it.index;
      req_entry_data <= it.data;
      req_entry_lifetime <= it.lifetime;
      req_tick_delta <= it.delta;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pool_model.apply_item(it);
      items_sent++;
   endtask

   // Stop offering and wait until every outstanding response has been checked.
   task automatic drain();
      req_valid <= 1'b0;
      while (pool_model.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input count_type value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      pool_model.set_limit(value);
      limits_used++;
   endtask

   // Hand-picked sequence: field extremes, every operation, an empty pool, waking an
   // alive slot, killing a dead slot, zero lifetimes and unused operation codes.
   task automatic run_directed();
      send_item(make_item(FN_WRITE, 0, '1, 31'h7FFF_FFFF, '0));
      send_item(make_item(FN_WRITE, 1023, '0, '0, '1));
      send_item(make_item(FN_WRITE, 1, 64'hA5A5_5A5A_0F0F_F0F0, 31'd5, 16'h00FF));
      send_item(make_item(FN_WRITE, 2, 64'h5A5A_A5A5_F0F0_0F0F, 31'd100, 16'hFF00));
      send_item(make_item(FN_WRITE, 3, 64'h1, 31'd1, 16'h1));
      send_item(make_item(FN_READ, 0, '0, '0, '0));
      send_item(make_item(FN_READ, 1023, '1, '1, '1));
      send_item(make_item(FN_KILL, 0, '0, '0, '0));
      send_item(make_item(FN_TICK, 0, '0, '0, '1));
      send_item(make_item(FN_WAKE, 0, '0, '0, '0));
      send_item(make_item(FN_WAKE, 1023, '0, '0, '0));
      send_item(make_item(FN_WAKE, 1023, '0, '0, '0));
      send_item(make_item(FN_WAKE, 1, '0, '0, '0));
      send_item(make_item(FN_READ, 2, '0, '0, '0));
      send_item(make_item(FN_TICK, 0, '0, '0, '0));
      send_item(make_item(FN_WAKE, 1023, '0, '0, '0));
      send_item(make_item(FN_KILL, 1023, '0, '0, '0));
      send_item(make_item(FN_TICK, 0, '0, '0, 16'd1));
      send_item(make_item(FN_TICK, 0, '0, '0, '1));
      send_item(make_item(FN_READ, 1, '0, '0, '0));
      send_item(make_item(func_type'(FN_TICK + 3'd1), 5, '1, '1, '1));
      send_item(make_item(func_type'(FN_TICK + 3'd2), 1023, '1, '1, '1));
      send_item(make_item(func_type'(FN_TICK + 3'd3), 0, '1, '1, '1));
      send_item(make_item(FN_KILL, 0, '0, '0, '0));
      send_item(make_item(FN_WAKE, 3, '0, '0, '0));
   endtask

   // Main sequence: reset, directed items, then one random phase per limit setting.
   initial begin
      pool_model = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      drain();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_limit(count_type'(phase_limit[p]));
         calm = (p == CALM_PHASE);
         repeat (phase_items[p]) send_item(random_item());
         drain();
         calm = 1'b0;
      end
      $display("Sent %0d items across %0d pool limit settings; %0d responses checked.",
               items_sent, limits_used, pool_model.checked);
      $display("Ticks: %0d, entries expired by them: %0d, field mismatches: %0d.",
               pool_model.ticks, pool_model.expired_total, pool_model.mismatches);
      if (pool_model.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
